[src/cpu_freq_residency_load_monitor_core_macros.svh]
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef CPU_FREQ_RESIDENCY_LOAD_MONITOR_CORE_MACROS_SVH
`define CPU_FREQ_RESIDENCY_LOAD_MONITOR_CORE_MACROS_SVH
`ifndef SYNTH
`define CFRLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CFRLM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define CFRLM_ASSERT(lbl, prop, msg)
`define CFRLM_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[src/cfrlm_pkg.sv]
package cfrlm_pkg;

  // sizes and reset values
  localparam int MaxFreqsDef  = 16;
  localparam int MulAW        = 32;
  localparam int MulBW        = 16;
  localparam int DataW        = 64;
  localparam logic [15:0] MaxFreqRst   = 16'd1000;
  localparam logic [4:0]  FreqCountRst = 5'd16;
  localparam logic [15:0] KhzPerMhz    = 16'd1000;
  localparam logic [15:0] PctScale     = 16'd100;

  // action codes
  localparam logic [2:0] ACT_LOAD  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_FREQ  = 3'd2;
  localparam logic [2:0] ACT_IDLE  = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_STARTED = 3'd1;
  localparam logic [2:0] ST_NO_FREQ     = 3'd2;
  localparam logic [2:0] ST_BAD_IDLE    = 3'd3;
  localparam logic [2:0] ST_BAD_SLOT    = 3'd4;

  // register indexes
  localparam logic REG_MAX_FREQ   = 1'b0;
  localparam logic REG_FREQ_COUNT = 1'b1;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] now_us;
    logic [31:0] freq_khz;
    logic [3:0]  table_index;
    logic [15:0] table_mhz;
    logic [1:0]  idle_state;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] load_pct;
    logic [6:0] active_pct;
  } out_item_t;

endpackage

[src/cpu_freq_residency_load_monitor_core.sv]
// table load, rejected items and unused codes go straight from accept to the result beat
// an idle change updates one residency counter; start searches the table entry by entry,
// and a frequency change adds accounting after the search (one table read port, shared multiplier)
// read walks all n table entries through the shared 32x16 multiplier and runs up to
// two bit-serial divisions; one item at a time
// reset clears all control state and marks every residency counter as zero at once
`include "cpu_freq_residency_load_monitor_core_macros.svh"
module cpu_freq_residency_load_monitor_core #(
  parameter int MAX_FREQS = cfrlm_pkg::MaxFreqsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  cfrlm_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output cfrlm_pkg::out_item_t  out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import cfrlm_pkg::*;

  localparam int IW = (MAX_FREQS > 1) ? $clog2(MAX_FREQS) : 1;
  localparam int CW = $clog2(MAX_FREQS + 1);
  localparam int AW = IW + 1;
  localparam int AccDepth = 2 ** AW;
  localparam int TblDepth = 2 ** IW;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_LK_RD  = 5'd2;
  localparam logic [4:0] S_LK_MUL = 5'd3;
  localparam logic [4:0] S_LK_CMP = 5'd4;
  localparam logic [4:0] S_AC_RD  = 5'd5;
  localparam logic [4:0] S_AC_WR  = 5'd6;
  localparam logic [4:0] S_R_INIT = 5'd7;
  localparam logic [4:0] S_R_RD   = 5'd8;
  localparam logic [4:0] S_R_GET  = 5'd9;
  localparam logic [4:0] S_R_IDL  = 5'd10;
  localparam logic [4:0] S_R_ADD  = 5'd11;
  localparam logic [4:0] S_M_LO   = 5'd12;
  localparam logic [4:0] S_M_HI   = 5'd13;
  localparam logic [4:0] S_M_FIN  = 5'd14;
  localparam logic [4:0] S_U1     = 5'd15;
  localparam logic [4:0] S_U2     = 5'd16;
  localparam logic [4:0] S_U3     = 5'd17;
  localparam logic [4:0] S_UDIV   = 5'd18;
  localparam logic [4:0] S_B1     = 5'd19;
  localparam logic [4:0] S_B2     = 5'd20;
  localparam logic [4:0] S_BDIV   = 5'd21;
  localparam logic [4:0] S_FIN    = 5'd22;
  localparam logic [4:0] S_DONE   = 5'd23;

  function automatic logic [6:0] pct_clamp(input logic [DataW-1:0] q);
    return (q > DataW'(PctScale)) ? 7'(PctScale) : q[6:0];
  endfunction

  // configuration registers
  logic [15:0] max_freq_q;
  logic [4:0]  freq_count_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_FREQ_COUNT) ? {27'b0, freq_count_q} : {16'b0, max_freq_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_freq_q   <= MaxFreqRst;
      freq_count_q <= FreqCountRst;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_MAX_FREQ:   max_freq_q   <= pwdata[15:0];
        REG_FREQ_COUNT: freq_count_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [4:0]  state_q, state_d, ret_q, ret_d;
  logic [CW-1:0] i_q, i_d, n_cnt, i_inc;
  logic [IW-1:0] i_idx, cur_f_q, cur_f_d, lk_idx_q, lk_idx_d;
  logic        cur_idle_q, cur_idle_d, started_q, started_d;
  logic        out_valid_q, out_valid_d;
  logic [DataW-1:0] last_upd_q, last_upd_d, last_read_q, last_read_d;
  in_item_t    item_q, item_d;
  out_item_t   out_q, out_d;
  logic [2:0]  st_q, st_d;
  logic [6:0]  util_q, util_d, busy_q, busy_d;
  logic [DataW-1:0] window_q, window_d, weighted_q, weighted_d, idle_sum_q, idle_sum_d;
  logic [DataW-1:0] delta_q, delta_d, op_q, op_d, prod_q, prod_d, den_q, den_d;
  logic [15:0] t_q, t_d;

  // shared units
  logic                   mul_en;
  logic [MulAW-1:0]       mul_a;
  logic [MulBW-1:0]       mul_b;
  logic [MulAW+MulBW-1:0] mul_p;
  logic                   div_start, div_done;
  logic [DataW-1:0]       div_den, div_quot;
  logic [47:0]            khz_ext;
  logic                   lk_match;

  // memories
  logic [15:0]      tbl_mem [TblDepth];
  logic [15:0]      tbl_rdata_q;
  logic [IW-1:0]    tbl_raddr, tbl_waddr;
  logic             tbl_we;
  logic [DataW-1:0] acc_mem [AccDepth];
  logic [DataW-1:0] acc_rdata_q, acc_wdata, acc_val;
  logic [AW-1:0]    acc_raddr, acc_waddr;
  logic             acc_we, acc_rv_q, vld_clr;
  logic [AccDepth-1:0] acc_vld_q;

  assign n_cnt = (32'(freq_count_q) < MAX_FREQS) ? CW'(freq_count_q) : CW'(MAX_FREQS);
  assign i_inc = i_q + CW'(1);
  assign i_idx = i_q[IW-1:0];
  assign acc_val = acc_rv_q ? acc_rdata_q : '0;
  assign tbl_waddr = IW'(item_q.table_index);
  assign khz_ext = 48'(item_q.freq_khz);
  assign lk_match = (khz_ext >= mul_p) && (khz_ext < mul_p + 48'(KhzPerMhz));
  assign div_den = (state_q == S_U3) ? den_q : window_q;
  assign in_stall_o = (state_q != S_IDLE);

  cfrlm_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  cfrlm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    i_d         = i_q;
    cur_f_d     = cur_f_q;
    lk_idx_d    = lk_idx_q;
    cur_idle_d  = cur_idle_q;
    started_d   = started_q;
    last_upd_d  = last_upd_q;
    last_read_d = last_read_q;
    item_d      = item_q;
    out_d       = out_q;
    st_d        = st_q;
    util_d      = util_q;
    busy_d      = busy_q;
    window_d    = window_q;
    weighted_d  = weighted_q;
    idle_sum_d  = idle_sum_q;
    delta_d     = delta_q;
    op_d        = op_q;
    prod_d      = prod_q;
    den_d       = den_q;
    t_d         = t_q;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    tbl_raddr   = '0;
    tbl_we      = 1'b0;
    acc_raddr   = '0;
    acc_waddr   = {cur_idle_q, cur_f_q};
    acc_wdata   = acc_val + delta_q;
    acc_we      = 1'b0;
    vld_clr     = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        st_d    = ST_OK;
        util_d  = '0;
        busy_d  = '0;
        i_d     = '0;
        state_d = S_DONE;
        case (item_q.action)
          ACT_LOAD: begin
            if (32'(item_q.table_index) >= MAX_FREQS) st_d = ST_BAD_SLOT;
            else tbl_we = 1'b1;
          end
          ACT_START, ACT_FREQ: begin
            if (!started_q && item_q.action == ACT_FREQ) st_d = ST_NOT_STARTED;
            else if (n_cnt == '0) st_d = ST_NO_FREQ;
            else state_d = S_LK_RD;
          end
          ACT_IDLE: begin
            if (!started_q) st_d = ST_NOT_STARTED;
            else if (item_q.idle_state[1]) st_d = ST_BAD_IDLE;
            else state_d = S_AC_RD;
          end
          ACT_READ: begin
            if (!started_q) st_d = ST_NOT_STARTED;
            else state_d = S_AC_RD;
          end
          default: ;
        endcase
      end
      // table search, first match wins
      S_LK_RD: begin
        tbl_raddr = i_idx;
        state_d   = S_LK_MUL;
      end
      S_LK_MUL: begin
        mul_en  = 1'b1;
        mul_a   = MulAW'(tbl_rdata_q);
        mul_b   = KhzPerMhz;
        state_d = S_LK_CMP;
      end
      S_LK_CMP: begin
        if (lk_match) begin
          if (item_q.action == ACT_START) begin
            vld_clr     = 1'b1;
            cur_f_d     = i_idx;
            cur_idle_d  = 1'b0;
            last_read_d = item_q.now_us;
            last_upd_d  = item_q.now_us;
            started_d   = 1'b1;
            state_d     = S_DONE;
          end else begin
            lk_idx_d = i_idx;
            state_d  = S_AC_RD;
          end
        end else if (i_inc == n_cnt) begin
          st_d    = ST_NO_FREQ;
          state_d = S_DONE;
        end else begin
          i_d     = i_inc;
          state_d = S_LK_RD;
        end
      end
      // add elapsed time to the current state's counter
      S_AC_RD: begin
        acc_raddr = {cur_idle_q, cur_f_q};
        delta_d   = item_q.now_us - last_upd_q;
        state_d   = S_AC_WR;
      end
      S_AC_WR: begin
        acc_we     = 1'b1;
        last_upd_d = item_q.now_us;
        state_d    = S_DONE;
        case (item_q.action)
          ACT_FREQ: cur_f_d = lk_idx_q;
          ACT_IDLE: cur_idle_d = item_q.idle_state[0];
          default:  state_d = S_R_INIT;
        endcase
      end
      // walk active and idle counters
      S_R_INIT: begin
        window_d   = item_q.now_us - last_read_q;
        weighted_d = '0;
        idle_sum_d = '0;
        i_d        = '0;
        state_d    = (n_cnt == '0) ? S_U1 : S_R_RD;
      end
      S_R_RD: begin
        acc_raddr = {1'b0, i_idx};
        tbl_raddr = i_idx;
        state_d   = S_R_GET;
      end
      S_R_GET: begin
        op_d      = acc_val;
        t_d       = tbl_rdata_q;
        acc_raddr = {1'b1, i_idx};
        state_d   = S_R_IDL;
      end
      S_R_IDL: begin
        idle_sum_d = idle_sum_q + acc_val;
        ret_d      = S_R_ADD;
        state_d    = S_M_LO;
      end
      S_R_ADD: begin
        weighted_d = weighted_q + prod_q;
        if (i_inc == n_cnt) begin
          state_d = S_U1;
        end else begin
          i_d     = i_inc;
          state_d = S_R_RD;
        end
      end
      // 64x16 product mod 2^64 in two halves
      S_M_LO: begin
        mul_en  = 1'b1;
        mul_a   = op_q[31:0];
        mul_b   = t_q;
        state_d = S_M_HI;
      end
      S_M_HI: begin
        prod_d  = DataW'(mul_p);
        mul_en  = 1'b1;
        mul_a   = op_q[63:32];
        mul_b   = t_q;
        state_d = S_M_FIN;
      end
      S_M_FIN: begin
        prod_d  = prod_q + {mul_p[31:0], 32'b0};
        state_d = ret_q;
      end
      // utilization
      S_U1: begin
        op_d    = window_q;
        t_d     = max_freq_q;
        ret_d   = S_U2;
        state_d = S_M_LO;
      end
      S_U2: begin
        den_d   = prod_q;
        op_d    = weighted_q;
        t_d     = PctScale;
        ret_d   = S_U3;
        state_d = S_M_LO;
      end
      S_U3: begin
        if (weighted_q == '0) begin
          util_d  = '0;
          state_d = S_B1;
        end else if (den_q == '0) begin
          util_d  = 7'(PctScale);
          state_d = S_B1;
        end else begin
          div_start = 1'b1;
          state_d   = S_UDIV;
        end
      end
      S_UDIV: begin
        if (div_done) begin
          util_d  = pct_clamp(div_quot);
          state_d = S_B1;
        end
      end
      // busy share
      S_B1: begin
        if (window_q <= idle_sum_q) begin
          busy_d  = '0;
          state_d = S_FIN;
        end else begin
          op_d    = window_q - idle_sum_q;
          t_d     = PctScale;
          ret_d   = S_B2;
          state_d = S_M_LO;
        end
      end
      S_B2: begin
        div_start = 1'b1;
        state_d   = S_BDIV;
      end
      S_BDIV: begin
        if (div_done) begin
          busy_d  = pct_clamp(div_quot);
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        vld_clr     = 1'b1;
        last_read_d = item_q.now_us;
        last_upd_d  = item_q.now_us;
        state_d     = S_DONE;
      end
      // result beat into the output register
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.status     = st_q;
          out_d.load_pct   = util_q;
          out_d.active_pct = busy_q;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      i_q         <= '0;
      cur_f_q     <= '0;
      cur_idle_q  <= 1'b0;
      started_q   <= 1'b0;
      last_upd_q  <= '0;
      last_read_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      i_q         <= i_d;
      cur_f_q     <= cur_f_d;
      cur_idle_q  <= cur_idle_d;
      started_q   <= started_d;
      last_upd_q  <= last_upd_d;
      last_read_q <= last_read_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    out_q      <= out_d;
    st_q       <= st_d;
    util_q     <= util_d;
    busy_q     <= busy_d;
    lk_idx_q   <= lk_idx_d;
    window_q   <= window_d;
    weighted_q <= weighted_d;
    idle_sum_q <= idle_sum_d;
    delta_q    <= delta_d;
    op_q       <= op_d;
    prod_q     <= prod_d;
    den_q      <= den_d;
    t_q        <= t_d;
  end

  // frequency table
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= item_q.table_mhz;
    end
    tbl_rdata_q <= tbl_mem[tbl_raddr];
  end

  // residency counters, an entry without its valid bit reads as zero
  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    acc_rdata_q <= acc_mem[acc_raddr];
    acc_rv_q    <= acc_vld_q[acc_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= '0;
    end else if (vld_clr) begin
      acc_vld_q <= '0;
    end else if (acc_we) begin
      acc_vld_q[acc_waddr] <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CFRLM_ASSERT_NEXT(a_accept_dispatch, in_valid_i && !in_stall_o, state_q == S_DISP, "accepted beat not dispatched")
  `CFRLM_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q) == S_DONE, "result beat outside done state")
  `CFRLM_ASSERT(a_pct_range, out_valid_q |-> out_q.load_pct <= 7'd100 && out_q.active_pct <= 7'd100, "percent above 100")
  `CFRLM_ASSERT(a_fail_zero_pct, out_valid_q && out_q.status != ST_OK |-> out_q.load_pct == 7'd0 && out_q.active_pct == 7'd0, "nonzero percent on failed beat")

endmodule

[src/cfrlm_mul.sv]
module cfrlm_mul (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [cfrlm_pkg::MulAW-1:0]            a_i,
  input  logic [cfrlm_pkg::MulBW-1:0]            b_i,
  output logic [cfrlm_pkg::MulAW+cfrlm_pkg::MulBW-1:0] p_o
);
  import cfrlm_pkg::*;

  logic [MulAW+MulBW-1:0] p_q;

  // registered 32x16 product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

[src/cfrlm_div.sv]
module cfrlm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cfrlm_pkg::DataW-1:0] num_i,
  input  logic [cfrlm_pkg::DataW-1:0] den_i,
  output logic                        done_o,
  output logic [cfrlm_pkg::DataW-1:0] quot_o
);
  import cfrlm_pkg::*;

  localparam int CntW = $clog2(DataW);

  logic            run_q, run_d, done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DataW-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [DataW:0]   trial, diff;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial  = {rem_q, quo_q[DataW-1]};
    diff   = trial - {1'b0, den_q};
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
    end else if (run_q) begin
      rem_d = diff[DataW] ? trial[DataW-1:0] : diff[DataW-1:0];
      quo_d = {quo_q[DataW-2:0], ~diff[DataW]};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(DataW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
